/* hw/rtl/partitioned_circular_queues_search_defines.svh */
// Assertion macros for the partitioned circular queues block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef PARTITIONED_CIRCULAR_QUEUES_SEARCH_DEFINES_SVH
`define PARTITIONED_CIRCULAR_QUEUES_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcqs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcqs: next-cycle check failed");

`endif

/* hw/rtl/pcqs_pkg.sv */
// Shared types, constants and helpers for the partitioned circular queues block.
// No dependencies; the interfaces, controller, datapath and top level refer to it by scoped names.
package pcqs_pkg;

    localparam int DATA_W          = 32;
    localparam int BOUND_W         = 5;
    localparam int COUNT_W         = 6;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;
    localparam int SLOT_SPAN       = 1 << BOUND_W;
    localparam int STORE_DEPTH_DEF = 32;
    localparam int NUM_QUEUES_DEF  = 2;

    // Reset bounds of the two queues that the register map reaches.
    localparam logic [BOUND_W-1:0] Q0_LOW_RST  = 5'd0;
    localparam logic [BOUND_W-1:0] Q0_HIGH_RST = 5'd9;
    localparam logic [BOUND_W-1:0] Q1_LOW_RST  = 5'd10;
    localparam logic [BOUND_W-1:0] Q1_HIGH_RST = 5'd19;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q0_LOW  = 2'd0,
        CFG_Q0_HIGH = 2'd1,
        CFG_Q1_LOW  = 2'd2,
        CFG_Q1_HIGH = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RDATA,
        S_SCAN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_en;
        logic do_insert;
        logic do_remove;
        logic scan_start;
        logic resolve;
        logic take_rdata;
        logic scan_step;
        logic scan_end;
        logic load_result;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            q_ok;
        logic            can_insert;
        logic            can_remove;
        logic            has_entries;
        logic            scan_hit;
        logic            scan_done;
        logic            out_busy;
    } t_stat;

    function automatic logic [BOUND_W-1:0] reset_low(input int q);
        if (q == 0) begin
            return Q0_LOW_RST;
        end else if (q == 1) begin
            return Q1_LOW_RST;
        end
        return '0;
    endfunction

    function automatic logic [BOUND_W-1:0] reset_high(input int q);
        if (q == 0) begin
            return Q0_HIGH_RST;
        end else if (q == 1) begin
            return Q1_HIGH_RST;
        end
        return '0;
    endfunction

endpackage

/* hw/rtl/pcqs_in_if.sv */
// Input channel: one request word (opcode, queue select, data) with valid/ready.
// Depends on pcqs_pkg for field widths.
interface pcqs_in_if;
    logic                                valid;
    logic                                ready;
    logic [pcqs_pkg::OP_W-1:0]           opcode;
    logic                                queue_select;
    logic signed [pcqs_pkg::DATA_W-1:0]  data_in;

    modport source (output valid, opcode, queue_select, data_in, input ready);
    modport sink   (input valid, opcode, queue_select, data_in, output ready);
endinterface

/* hw/rtl/pcqs_out_if.sv */
// Output channel: one result word (success, data) with valid/ready.
// Depends on pcqs_pkg for field widths.
interface pcqs_out_if;
    logic                                valid;
    logic                                ready;
    logic                                success;
    logic signed [pcqs_pkg::DATA_W-1:0]  data_out;

    modport source (output valid, success, data_out, input ready);
    modport sink   (input valid, success, data_out, output ready);
endinterface

/* hw/rtl/pcqs_ctrl.sv */
// Controller state machine: sequences one request word at a time through the datapath.
// Depends on pcqs_pkg (state type, command and status structs, opcodes).
module pcqs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcqs_pkg::t_stat i_stat,
    output pcqs_pkg::t_cmd  o_cmd
);

    pcqs_pkg::t_state r_state;
    pcqs_pkg::t_state n_state;

    logic w_go_insert;
    logic w_go_remove;
    logic w_go_search;

    // Decide what the captured request will do.
    always_comb begin
        w_go_insert = 1'b0;
        w_go_remove = 1'b0;
        w_go_search = 1'b0;
        unique case (pcqs_pkg::t_op'(i_stat.op))
            pcqs_pkg::OP_INSERT: w_go_insert = i_stat.q_ok && i_stat.can_insert;
            pcqs_pkg::OP_REMOVE: w_go_remove = i_stat.q_ok && i_stat.can_remove;
            pcqs_pkg::OP_SEARCH: w_go_search = i_stat.q_ok && i_stat.has_entries;
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcqs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcqs_pkg::S_IDLE: begin
                if (i_stat.in_valid) n_state = pcqs_pkg::S_DISPATCH;
            end
            pcqs_pkg::S_DISPATCH: begin
                if (w_go_remove) begin
                    n_state = pcqs_pkg::S_RDATA;
                end else if (w_go_search) begin
                    n_state = pcqs_pkg::S_SCAN;
                end else begin
                    n_state = pcqs_pkg::S_FINISH;
                end
            end
            pcqs_pkg::S_RDATA: n_state = pcqs_pkg::S_FINISH;
            pcqs_pkg::S_SCAN: begin
                if (i_stat.scan_done) n_state = pcqs_pkg::S_FINISH;
            end
            pcqs_pkg::S_FINISH: begin
                if (!i_stat.out_busy) n_state = pcqs_pkg::S_IDLE;
            end
            default: n_state = pcqs_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pcqs_pkg::S_IDLE: o_cmd.accept_en = 1'b1;
            pcqs_pkg::S_DISPATCH: begin
                o_cmd.resolve    = 1'b1;
                o_cmd.do_insert  = w_go_insert;
                o_cmd.do_remove  = w_go_remove;
                o_cmd.scan_start = w_go_search;
            end
            pcqs_pkg::S_RDATA: o_cmd.take_rdata = 1'b1;
            pcqs_pkg::S_SCAN: begin
                o_cmd.scan_step = !i_stat.scan_done;
                o_cmd.scan_end  = i_stat.scan_done;
            end
            pcqs_pkg::S_FINISH: o_cmd.load_result = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

/* hw/rtl/pcqs_dp.sv */
// Datapath: queue bounds, heads and counts, the shared word store, scan logic
// and the result register. Depends on pcqs_pkg.
module pcqs_dp #(
    parameter int STORE_DEPTH = pcqs_pkg::STORE_DEPTH_DEF,
    parameter int NUM_QUEUES  = pcqs_pkg::NUM_QUEUES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcqs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcqs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic [pcqs_pkg::OP_W-1:0]           i_opcode,
    input  logic                                i_queue_select,
    input  logic signed [pcqs_pkg::DATA_W-1:0]  i_data_in,
    input  logic                                i_out_ready,
    input  pcqs_pkg::t_cmd                      i_cmd,
    output pcqs_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic                                o_success,
    output logic signed [pcqs_pkg::DATA_W-1:0]  o_data_out
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int BW = pcqs_pkg::BOUND_W;
    localparam int CW = pcqs_pkg::COUNT_W;
    localparam int DW = pcqs_pkg::DATA_W;
    localparam int SW = CW + 1;

    // Per-queue segment state.
    logic [BW-1:0] r_low   [NUM_QUEUES];
    logic [BW-1:0] r_high  [NUM_QUEUES];
    logic [BW-1:0] r_head  [NUM_QUEUES];
    logic [CW-1:0] r_count [NUM_QUEUES];

    // Captured request word.
    logic [pcqs_pkg::OP_W-1:0] r_op;
    logic                      r_qsel;
    logic [DW-1:0]             r_key;

    // Scan state and store read port.
    logic [BW-1:0] r_scan_idx;
    logic [CW-1:0] r_scan_left;
    logic          r_cmp_valid;
    logic [DW-1:0] r_mem [STORE_DEPTH];
    logic [DW-1:0] r_rdata;

    // Pending and delivered result.
    logic          r_ok;
    logic [DW-1:0] r_dout;
    logic          r_out_valid;
    logic          r_success;
    logic [DW-1:0] r_data_out;

    logic          w_q_ok;
    logic [QW-1:0] w_qi;
    logic [BW-1:0] w_low;
    logic [BW-1:0] w_high;
    logic [BW-1:0] w_head;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_cap;
    logic [SW-1:0] w_sum;
    logic [BW-1:0] w_tail;
    logic [BW-1:0] w_head_adv;
    logic [BW-1:0] w_scan_adv;
    logic          w_cfg_q;
    logic          w_cfg_high;
    logic          w_cfg_ok;
    logic          w_we;
    logic          w_re;
    logic [BW-1:0] w_rd_idx;
    logic [AW-1:0] w_wr_slot;
    logic [AW-1:0] w_rd_slot;
    logic          w_hit;
    logic [AW-1:0] w_slot_lut [pcqs_pkg::SLOT_SPAN];

    // Next index inside a segment, wrapping from high back to low.
    function automatic logic [BW-1:0] seg_advance(input logic [BW-1:0] idx,
                                                  input logic [BW-1:0] lo,
                                                  input logic [BW-1:0] hi);
        logic [BW:0] nxt;
        nxt = {1'b0, idx} + (BW+1)'(1);
        return (nxt > {1'b0, hi}) ? lo : nxt[BW-1:0];
    endfunction

    // Index to store slot: the index space wraps modulo the store depth.
    for (genvar k = 0; k < pcqs_pkg::SLOT_SPAN; k++) begin : g_slot
        assign w_slot_lut[k] = AW'(k % STORE_DEPTH);
    end

    // Selected queue and its derived geometry.
    assign w_q_ok  = (32'(r_qsel) < NUM_QUEUES);
    assign w_qi    = w_q_ok ? QW'(r_qsel) : '0;
    assign w_low   = r_low[w_qi];
    assign w_high  = r_high[w_qi];
    assign w_head  = r_head[w_qi];
    assign w_count = r_count[w_qi];
    assign w_cap   = (w_low > w_high) ? '0
                   : ({1'b0, w_high} - {1'b0, w_low} + CW'(1));

    // Tail is head plus count, folded back once into the segment.
    assign w_sum  = {2'b00, w_head} + {1'b0, w_count};
    assign w_tail = (w_sum > {2'b00, w_high}) ? BW'(w_sum - {1'b0, w_cap}) : BW'(w_sum);

    assign w_head_adv = seg_advance(w_head, w_low, w_high);
    assign w_scan_adv = seg_advance(r_scan_idx, w_low, w_high);

    // Register index decode.
    always_comb begin
        w_cfg_q    = 1'b0;
        w_cfg_high = 1'b0;
        unique case (pcqs_pkg::t_cfg_reg'(i_cfg_index))
            pcqs_pkg::CFG_Q0_LOW:  begin w_cfg_q = 1'b0; w_cfg_high = 1'b0; end
            pcqs_pkg::CFG_Q0_HIGH: begin w_cfg_q = 1'b0; w_cfg_high = 1'b1; end
            pcqs_pkg::CFG_Q1_LOW:  begin w_cfg_q = 1'b1; w_cfg_high = 1'b0; end
            pcqs_pkg::CFG_Q1_HIGH: begin w_cfg_q = 1'b1; w_cfg_high = 1'b1; end
            default: ;
        endcase
    end
    assign w_cfg_ok = i_cfg_we && (32'(w_cfg_q) < NUM_QUEUES);

    // Queue bookkeeping: a bound write empties its queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_low[q]   <= pcqs_pkg::reset_low(q);
                r_high[q]  <= pcqs_pkg::reset_high(q);
                r_head[q]  <= pcqs_pkg::reset_low(q);
                r_count[q] <= '0;
            end
        end else begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (w_cfg_ok && (QW'(w_cfg_q) == QW'(q))) begin
                    if (w_cfg_high) begin
                        r_high[q] <= i_cfg_data;
                        r_head[q] <= r_low[q];
                    end else begin
                        r_low[q]  <= i_cfg_data;
                        r_head[q] <= i_cfg_data;
                    end
                    r_count[q] <= '0;
                end else if (i_cmd.do_insert && (w_qi == QW'(q))) begin
                    r_count[q] <= r_count[q] + CW'(1);
                end else if (i_cmd.do_remove && (w_qi == QW'(q))) begin
                    r_head[q]  <= w_head_adv;
                    r_count[q] <= r_count[q] - CW'(1);
                end
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_en && i_in_valid) begin
            r_op   <= i_opcode;
            r_qsel <= i_queue_select;
            r_key  <= i_data_in;
        end
    end

    // Store access: one write and one registered read per cycle.
    assign w_we      = i_cmd.do_insert;
    assign w_re      = i_cmd.do_remove || (i_cmd.scan_step && (r_scan_left != '0));
    assign w_rd_idx  = i_cmd.do_remove ? w_head : r_scan_idx;
    assign w_wr_slot = w_slot_lut[w_tail];
    assign w_rd_slot = w_slot_lut[w_rd_idx];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_slot] <= r_key;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_rd_slot];
        end
    end

    // Search walk: issue one read per cycle, compare it the cycle after.
    assign w_hit = r_cmp_valid && (r_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx  <= w_head;
            r_scan_left <= w_count;
        end else if (i_cmd.scan_step && (r_scan_left != '0)) begin
            r_scan_idx  <= w_scan_adv;
            r_scan_left <= r_scan_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan_start || i_cmd.scan_end) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_valid <= (r_scan_left != '0);
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_ok   <= i_cmd.do_insert || i_cmd.do_remove;
            r_dout <= '0;
        end else if (i_cmd.take_rdata) begin
            r_dout <= r_rdata;
        end else if (i_cmd.scan_end) begin
            r_ok <= w_hit;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_success  <= r_ok;
            r_data_out <= r_dout;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_success   = r_success;
    assign o_data_out  = r_data_out;

    // Status to the controller.
    always_comb begin
        o_stat             = '0;
        o_stat.in_valid    = i_in_valid;
        o_stat.op          = r_op;
        o_stat.q_ok        = w_q_ok;
        o_stat.can_insert  = (w_count < w_cap);
        o_stat.can_remove  = (w_count != '0) && (w_cap != '0);
        o_stat.has_entries = (w_count != '0);
        o_stat.scan_hit    = w_hit;
        o_stat.scan_done   = w_hit || ((r_scan_left == '0) && !r_cmp_valid);
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

endmodule

/* hw/rtl/partitioned_circular_queues_search.sv */
// Channel   Dir  Handshake            Word
// i_in      in   valid/ready          opcode, queue_select, data_in
// o_out     out  valid/ready          success, data_out
// i_cfg_*   in   write enable only    register index, bound value
//
// One request word at a time. Insert and failed requests pass through the dispatch
// and finishing steps, a remove adds a read-data step, and a search walks the live
// entries from the head, stopping at the first match: the single read port of the
// word store feeds the comparator one entry per cycle. The next word is accepted
// in the cycle after the result is loaded, and a stalled output holds only the
// finishing step. Reset is synchronous; the word store is not cleared.
// Depends on pcqs_pkg, the two channel interfaces, pcqs_ctrl and pcqs_dp.
`include "partitioned_circular_queues_search_defines.svh"

module partitioned_circular_queues_search #(
    parameter int STORE_DEPTH = pcqs_pkg::STORE_DEPTH_DEF,
    parameter int NUM_QUEUES  = pcqs_pkg::NUM_QUEUES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pcqs_in_if.sink                           i_in,
    pcqs_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [pcqs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcqs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pcqs_pkg::t_cmd  w_cmd;
    pcqs_pkg::t_stat w_stat;

    // Sequencer.
    pcqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Queue state, store and result register.
    pcqs_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in.valid),
        .i_opcode       (i_in.opcode),
        .i_queue_select (i_in.queue_select),
        .i_data_in      (i_in.data_in),
        .i_out_ready    (o_out.ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .o_success      (o_out.success),
        .o_data_out     (o_out.data_out)
    );

    assign i_in.ready = w_cmd.accept_en;

    // Only one word is in flight: no acceptance right after one.
    `PCQS_ASSERT_NEXT(a_one_in_flight, i_in.valid && i_in.ready, !i_in.ready)

    // A failed result never carries data; a search result carries none either.
    `PCQS_ASSERT_NOW(a_fail_no_data, o_out.valid && !o_out.success, o_out.data_out == '0)

    // Loading a result presents it on the next cycle.
    `PCQS_ASSERT_NEXT(a_load_shows, w_cmd.load_result, o_out.valid)

endmodule
